@@ hdl/wvfm_pkg.sv @@
// shared types and constants for the weighted variance foreground mask pipeline
package wvfm_pkg;

    localparam int LANES     = 3;
    localparam int PIX_W     = 8;
    localparam int WGT_W     = 16;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int FRAC_W    = 16;
    localparam int MEAN_W    = PIX_W + FRAC_W;          // q8.16
    localparam int MSUM_W    = MEAN_W + 2;              // three-term sum headroom
    localparam int SQ_W      = 2 * MEAN_W;              // q16.32
    localparam int HALF_W    = SQ_W / 2;
    localparam int PART_W    = HALF_W + WGT_W;
    localparam int TERM_W    = SQ_W + WGT_W;            // q16.48
    localparam int VAR_W     = TERM_W + 2;
    localparam int VFRAC_W   = 48;
    localparam int STAGES    = 8;

    localparam logic [MEAN_W-1:0] MEAN_MAX = '1;
    localparam logic [PIX_W-1:0]  MASK_FG  = 8'hFF;
    localparam logic [PIX_W-1:0]  MASK_BG  = 8'h00;

    localparam logic [WGT_W-1:0]  WEIGHT_RST    = 16'd21845;
    localparam logic [CFG_W-1:0]  THRESHOLD_RST = 16'd32000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WEIGHT_A  = 2'd0,
        CFG_WEIGHT_B  = 2'd1,
        CFG_WEIGHT_C  = 2'd2,
        CFG_THRESHOLD = 2'd3
    } t_cfg_idx;

    typedef logic [LANES-1:0][PIX_W-1:0]  t_pix_vec;
    typedef logic [LANES-1:0][WGT_W-1:0]  t_wgt_vec;
    typedef logic [LANES-1:0][SQ_W-1:0]   t_sq_vec;
    typedef logic [LANES-1:0][TERM_W-1:0] t_term_vec;

    // load strobes for the two register stages inside one pipeline section
    typedef struct packed {
        logic load0;
        logic load1;
    } t_stg_en;

endpackage

@@ hdl/wvfm_mean.sv @@
// pipeline section: per-lane weighted products, then saturated q8.16 mean
module wvfm_mean (
    input  logic               i_clk,
    input  wvfm_pkg::t_stg_en  i_en,
    input  wvfm_pkg::t_pix_vec i_pix,
    input  wvfm_pkg::t_wgt_vec i_weight,
    output wvfm_pkg::t_pix_vec o_pix,
    output logic [wvfm_pkg::MEAN_W-1:0] o_mean
);
    import wvfm_pkg::*;

    logic [LANES-1:0][MEAN_W-1:0] r_prod;
    t_pix_vec                     r_pix0;
    t_pix_vec                     r_pix1;
    logic [MEAN_W-1:0]            r_mean;
    logic [MSUM_W-1:0]            n_sum;
    logic [MEAN_W-1:0]            n_mean;

    always_ff @(posedge i_clk) begin
        if (i_en.load0) begin
            for (int i = 0; i < LANES; i++) begin
                r_prod[i] <= MEAN_W'(i_pix[i]) * MEAN_W'(i_weight[i]);
            end
            r_pix0 <= i_pix;
        end
    end

    always_comb begin
        n_sum = '0;
        for (int i = 0; i < LANES; i++) begin
            n_sum = n_sum + MSUM_W'(r_prod[i]);
        end
        // weights summing above one can push the mean past q8.16
        if (n_sum[MSUM_W-1:MEAN_W] != '0) begin
            n_mean = MEAN_MAX;
        end else begin
            n_mean = n_sum[MEAN_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.load1) begin
            r_mean <= n_mean;
            r_pix1 <= r_pix0;
        end
    end

    assign o_pix  = r_pix1;
    assign o_mean = r_mean;

endmodule

@@ hdl/wvfm_sqdev.sv @@
// pipeline section: absolute deviation from the mean, then its square
module wvfm_sqdev (
    input  logic               i_clk,
    input  wvfm_pkg::t_stg_en  i_en,
    input  wvfm_pkg::t_pix_vec i_pix,
    input  logic [wvfm_pkg::MEAN_W-1:0] i_mean,
    output wvfm_pkg::t_sq_vec  o_sq
);
    import wvfm_pkg::*;

    logic [LANES-1:0][MEAN_W-1:0] r_dev;
    logic [LANES-1:0][MEAN_W-1:0] n_dev;
    t_sq_vec                      r_sq;

    always_comb begin
        logic [MEAN_W-1:0] lvl;
        for (int i = 0; i < LANES; i++) begin
            lvl = {i_pix[i], FRAC_W'(0)};
            n_dev[i] = (lvl >= i_mean) ? (lvl - i_mean) : (i_mean - lvl);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.load0) begin
            r_dev <= n_dev;
        end
        if (i_en.load1) begin
            for (int i = 0; i < LANES; i++) begin
                r_sq[i] <= SQ_W'(r_dev[i]) * SQ_W'(r_dev[i]);
            end
        end
    end

    assign o_sq = r_sq;

endmodule

@@ hdl/wvfm_wsq.sv @@
// pipeline section: squared deviation times weight, split in two partial products
module wvfm_wsq (
    input  logic               i_clk,
    input  wvfm_pkg::t_stg_en  i_en,
    input  wvfm_pkg::t_sq_vec  i_sq,
    input  wvfm_pkg::t_wgt_vec i_weight,
    output wvfm_pkg::t_term_vec o_term
);
    import wvfm_pkg::*;

    logic [LANES-1:0][PART_W-1:0] r_hi;
    logic [LANES-1:0][PART_W-1:0] r_lo;
    t_term_vec                    r_term;

    always_ff @(posedge i_clk) begin
        if (i_en.load0) begin
            for (int i = 0; i < LANES; i++) begin
                r_hi[i] <= PART_W'(i_sq[i][SQ_W-1:HALF_W]) * PART_W'(i_weight[i]);
                r_lo[i] <= PART_W'(i_sq[i][HALF_W-1:0]) * PART_W'(i_weight[i]);
            end
        end
        if (i_en.load1) begin
            // exact product stays below 2^64, no carry out
            for (int i = 0; i < LANES; i++) begin
                r_term[i] <= {r_hi[i], HALF_W'(0)} + TERM_W'(r_lo[i]);
            end
        end
    end

    assign o_term = r_term;

endmodule

@@ hdl/weighted_variance_foreground_mask_unit.sv @@
// top level: config registers, pipeline control, variance sum and threshold compare
//
// usage
// - pixel channel: i_pixel_valid / o_pixel_ready carry one request holding the
//   same pixel from three consecutive frames (i_pixel_a, i_pixel_b, i_pixel_c)
// - mask channel: o_mask_valid / i_mask_ready carry one result per request,
//   o_mask_value is 255 for foreground and 0 for background, in request order
// - config port: i_cfg_we writes i_cfg_data into register i_cfg_idx
//   (0..2 weights a..c in unsigned q0.16, 3 integer variance threshold);
//   write only while no request is in flight
// - structure: 8 register stages, two for the mean, two for the squared
//   deviations, two for the weighted squares, one for the sum, one for the compare
// - throughput: one request per cycle while the receiver is ready, each of the 8
//   stages then taking a new request each cycle; no multiply exceeds 24 by 24 bits
// - stall: each stage holds when it is full and the next cannot take it, so
//   empty stages keep filling while the receiver stalls; o_pixel_ready drops
//   only once all 8 stages hold a request
// - reset: synchronous, active low; clears all stage valid bits and loads
//   the weights with 21845 and the threshold with 32000
module weighted_variance_foreground_mask_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [wvfm_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [wvfm_pkg::CFG_W-1:0]      i_cfg_data,
    input  logic                            i_pixel_valid,
    output logic                            o_pixel_ready,
    input  logic [wvfm_pkg::PIX_W-1:0]      i_pixel_a,
    input  logic [wvfm_pkg::PIX_W-1:0]      i_pixel_b,
    input  logic [wvfm_pkg::PIX_W-1:0]      i_pixel_c,
    output logic                            o_mask_valid,
    input  logic                            i_mask_ready,
    output logic [wvfm_pkg::PIX_W-1:0]      o_mask_value
);
    import wvfm_pkg::*;

    // configuration registers
    t_wgt_vec        r_weight;
    logic [CFG_W-1:0] r_threshold;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight    <= {LANES{WEIGHT_RST}};
            r_threshold <= THRESHOLD_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_WEIGHT_A:  r_weight[0] <= i_cfg_data;
                CFG_WEIGHT_B:  r_weight[1] <= i_cfg_data;
                CFG_WEIGHT_C:  r_weight[2] <= i_cfg_data;
                CFG_THRESHOLD: r_threshold <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // stage valid bits and per-stage ready chain
    logic [STAGES-1:0] r_vld;
    logic [STAGES-1:0] stg_rdy;
    logic [STAGES-1:0] stg_vin;
    logic [STAGES-1:0] stg_load;

    always_comb begin
        stg_rdy[STAGES-1] = !r_vld[STAGES-1] || i_mask_ready;
        for (int k = STAGES-2; k >= 0; k--) begin
            stg_rdy[k] = !r_vld[k] || stg_rdy[k+1];
        end
        stg_vin = {r_vld[STAGES-2:0], i_pixel_valid};
        // payload only moves when a request actually enters the stage
        stg_load = stg_rdy & stg_vin;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < STAGES; k++) begin
                if (stg_rdy[k]) begin
                    r_vld[k] <= stg_vin[k];
                end
            end
        end
    end

    assign o_pixel_ready = stg_rdy[0];
    assign o_mask_valid  = r_vld[STAGES-1];

    // stages 0 and 1: weighted mean
    t_pix_vec          in_pix;
    t_pix_vec          mean_pix;
    logic [MEAN_W-1:0] mean;
    t_stg_en           mean_en;

    assign in_pix  = {i_pixel_c, i_pixel_b, i_pixel_a};
    assign mean_en = '{load0: stg_load[0], load1: stg_load[1]};

    wvfm_mean u_mean (
        .i_clk    (i_clk),
        .i_en     (mean_en),
        .i_pix    (in_pix),
        .i_weight (r_weight),
        .o_pix    (mean_pix),
        .o_mean   (mean)
    );

    // stages 2 and 3: squared deviations
    t_sq_vec sq;
    t_stg_en sq_en;

    assign sq_en = '{load0: stg_load[2], load1: stg_load[3]};

    wvfm_sqdev u_sqdev (
        .i_clk  (i_clk),
        .i_en   (sq_en),
        .i_pix  (mean_pix),
        .i_mean (mean),
        .o_sq   (sq)
    );

    // stages 4 and 5: weighted squared deviations in q16.48
    t_term_vec term;
    t_stg_en   wsq_en;

    assign wsq_en = '{load0: stg_load[4], load1: stg_load[5]};

    wvfm_wsq u_wsq (
        .i_clk    (i_clk),
        .i_en     (wsq_en),
        .i_sq     (sq),
        .i_weight (r_weight),
        .o_term   (term)
    );

    // stage 6: variance sum, two guard bits instead of saturation since any
    // sum past 2^64 is above every threshold anyway
    logic [VAR_W-1:0] r_var;
    logic [VAR_W-1:0] n_var;

    always_comb begin
        n_var = '0;
        for (int i = 0; i < LANES; i++) begin
            n_var = n_var + VAR_W'(term[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (stg_load[6]) begin
            r_var <= n_var;
        end
    end

    // stage 7: strict compare against the threshold scaled to q16.48
    logic [VAR_W-1:0] var_limit;
    logic [PIX_W-1:0] r_mask;

    assign var_limit = {(VAR_W-CFG_W-VFRAC_W)'(0), r_threshold, VFRAC_W'(0)};

    always_ff @(posedge i_clk) begin
        if (stg_load[7]) begin
            r_mask <= (r_var > var_limit) ? MASK_FG : MASK_BG;
        end
    end

    assign o_mask_value = r_mask;

    // a full pipeline facing a stalled receiver must refuse new requests
    ap_full_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((&r_vld) && !i_mask_ready) |-> !o_pixel_ready)
        else $error("pixel request accepted while the pipeline is full and stalled");

    // a stalled result must neither vanish nor change
    ap_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_mask_valid && !i_mask_ready) |=> (o_mask_valid && $stable(o_mask_value)))
        else $error("stalled mask result was lost or changed");

    // the mask only ever carries the foreground or background code
    ap_mask_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mask_valid |-> (o_mask_value == MASK_FG || o_mask_value == MASK_BG))
        else $error("mask value is neither foreground nor background");

endmodule
